// ===== rtl/mtb_pkg.sv =====
// Shared types and constants of the token bucket table.
// Used by the valid map, the bucket store and the top level; no dependencies.
package mtb_pkg;

    localparam int OPC_W      = 3;
    localparam int BUCKET_W   = 10;
    localparam int AMOUNT_W   = 16;
    localparam int RATE_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 10;
    localparam int LEVEL_W    = 32;
    localparam int MAP_WORD_W = 32;
    localparam int MAP_BIT_W  = 5;

    localparam int DEF_NUM_BUCKETS = 1024;
    localparam int DEF_LEVEL_BITS  = 32;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [AMOUNT_W-1:0]  amount_t;
    typedef logic [RATE_W-1:0]    rate_t;
    typedef logic [LEVEL_W-1:0]   level_out_t;
    typedef logic [BUCKET_W-1:0]  bucket_t;
    typedef logic [MAP_BIT_W-1:0] map_bit_t;

    typedef enum logic [OPC_W-1:0] {
        OPC_TICK    = 3'd0,
        OPC_CREATE  = 3'd1,
        OPC_DESTROY = 3'd2,
        OPC_FETCH   = 3'd3,
        OPC_RETURN  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_SHORT   = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_UNUSED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        LVL_LOAD,
        LVL_ADD_RATE,
        LVL_ADD_AMT,
        LVL_SUB_AMT
    } lvl_op_t;

    typedef struct packed {
        logic    en;
        lvl_op_t op;
    } lvl_cmd_t;

    typedef struct packed {
        logic en;
        logic set;
    } map_wr_t;

endpackage

// ===== rtl/multi_token_bucket_table.sv =====
// Token bucket table top level: command sequencer and result register.
// Depends on mtb_pkg, mtb_valid_map and mtb_bucket_store.
//
// Commands come in on the s_ channel, one beat each, and every command gives
// exactly one result beat on the m_ channel, in order.
// Destroy, fetch, return and rejected commands read the memories when the beat
// is accepted, then update and write back in S_OP, where the result is loaded;
// no new command is taken until that result is in the output register.
// Create scans the valid map one 32-bucket word per cycle for the lowest free
// slot. Tick walks every bucket through the single write port of the bucket
// store, one per cycle. After reset the valid map is cleared, one word per
// cycle, all ceil(NUM_BUCKETS/32) words (32 at the default size); s_tready
// stays low meanwhile.
// A result waits in the output register while m_tready is low; the next command
// is still accepted and its result parks in a hold register, after which the
// sequencer waits for the output register to drain.
module multi_token_bucket_table #(
    parameter int NUM_BUCKETS = mtb_pkg::DEF_NUM_BUCKETS,
    parameter int LEVEL_BITS  = mtb_pkg::DEF_LEVEL_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bucket[9:0], amount[25:10], rate[41:26]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // slot[9:0], granted[25:10], level[57:26]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int NUM_WORDS =
        (NUM_BUCKETS + mtb_pkg::MAP_WORD_W - 1) / mtb_pkg::MAP_WORD_W;
    localparam int WORD_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ADDR_BITS = $clog2(NUM_BUCKETS);
    localparam int CNT_W     = $clog2(NUM_BUCKETS + 1);

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    localparam word_t LAST_WORD = word_t'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_TICK,
        S_HOLD
    } state_t;

    state_t               state_reg, state_next;
    mtb_pkg::opcode_t     op_reg, op_next;
    mtb_pkg::bucket_t     bkt_reg, bkt_next;
    mtb_pkg::amount_t     amt_reg, amt_next;
    mtb_pkg::rate_t       rate_reg, rate_next;
    cnt_t                 cnt_reg, cnt_next;
    logic                 wb_reg, wb_next;
    addr_t                wb_addr_reg, wb_addr_next;
    word_t                wb_word_reg, wb_word_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    mtb_pkg::status_t     m_status_reg, m_status_next;
    mtb_pkg::slot_t       m_slot_reg, m_slot_next;
    mtb_pkg::amount_t     m_granted_reg, m_granted_next;
    mtb_pkg::level_out_t  m_level_reg, m_level_next;

    mtb_pkg::status_t     res_status_reg, res_status_next;
    mtb_pkg::slot_t       res_slot_reg, res_slot_next;
    mtb_pkg::amount_t     res_granted_reg, res_granted_next;
    mtb_pkg::level_out_t  res_level_reg, res_level_next;

    logic                 done;
    mtb_pkg::status_t     done_status;
    mtb_pkg::slot_t       done_slot;
    mtb_pkg::amount_t     done_granted;
    mtb_pkg::level_out_t  done_level;
    logic                 out_free;

    logic                 in_accept;
    mtb_pkg::opcode_t     in_opcode;
    mtb_pkg::bucket_t     in_bucket;
    mtb_pkg::amount_t     in_amount;
    mtb_pkg::rate_t       in_rate;
    addr_t                in_addr;
    logic                 in_bkt_ok;
    addr_t                bkt_addr;
    logic                 bkt_ok;
    addr_t                scan_addr;

    logic                 vm_busy;
    logic                 vm_rd_en;
    word_t                vm_rd_word;
    mtb_pkg::map_bit_t    vm_rd_bit;
    mtb_pkg::map_wr_t     vm_wr;
    word_t                vm_wr_word;
    mtb_pkg::map_bit_t    vm_wr_bit;
    logic                 vm_bit_valid;
    logic                 vm_free_found;
    mtb_pkg::map_bit_t    vm_free_bit;

    logic                 bs_rd_en;
    addr_t                bs_rd_addr;
    mtb_pkg::lvl_cmd_t    bs_cmd;
    addr_t                bs_wr_addr;
    level_t               bs_level_q;
    level_t               bs_new_level;
    logic                 bs_short;

    mtb_valid_map #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_valid_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .busy       (vm_busy),
        .rd_en      (vm_rd_en),
        .rd_word    (vm_rd_word),
        .rd_bit     (vm_rd_bit),
        .wr         (vm_wr),
        .wr_word    (vm_wr_word),
        .wr_bit     (vm_wr_bit),
        .bit_valid  (vm_bit_valid),
        .free_found (vm_free_found),
        .free_bit   (vm_free_bit)
    );

    mtb_bucket_store #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_bucket_store (
        .aclk      (aclk),
        .rd_en     (bs_rd_en),
        .rd_addr   (bs_rd_addr),
        .cmd       (bs_cmd),
        .wr_addr   (bs_wr_addr),
        .amount    (amt_reg),
        .rate_in   (rate_reg),
        .level_q   (bs_level_q),
        .new_level (bs_new_level),
        .is_short  (bs_short)
    );

    assign s_tready  = (state_reg == S_IDLE) && !vm_busy;
    assign in_accept = s_tvalid && s_tready;
    assign in_opcode = mtb_pkg::opcode_t'(s_tuser[2:0]);
    assign in_bucket = s_tdata[9:0];
    assign in_amount = s_tdata[25:10];
    assign in_rate   = s_tdata[41:26];
    assign in_addr   = addr_t'(in_bucket);
    assign in_bkt_ok = 32'(in_bucket) < 32'(NUM_BUCKETS);
    assign bkt_addr  = addr_t'(bkt_reg);
    assign bkt_ok    = 32'(bkt_reg) < 32'(NUM_BUCKETS);
    assign scan_addr = addr_t'({wb_word_reg, vm_free_bit});
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        bkt_next     = bkt_reg;
        amt_next     = amt_reg;
        rate_next    = rate_reg;
        cnt_next     = cnt_reg;
        wb_next      = wb_reg;
        wb_addr_next = wb_addr_reg;
        wb_word_next = wb_word_reg;

        vm_rd_en     = 1'b0;
        vm_rd_word   = '0;
        vm_rd_bit    = '0;
        vm_wr        = '{en: 1'b0, set: 1'b0};
        vm_wr_word   = '0;
        vm_wr_bit    = '0;
        bs_rd_en     = 1'b0;
        bs_rd_addr   = '0;
        bs_cmd       = '{en: 1'b0, op: mtb_pkg::LVL_LOAD};
        bs_wr_addr   = '0;

        done         = 1'b0;
        done_status  = mtb_pkg::STAT_OK;
        done_slot    = '0;
        done_granted = '0;
        done_level   = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    op_next   = in_opcode;
                    bkt_next  = in_bucket;
                    amt_next  = in_amount;
                    rate_next = in_rate;
                    cnt_next  = '0;
                    wb_next   = 1'b0;
                    if (in_opcode == mtb_pkg::OPC_TICK) begin
                        state_next = S_TICK;
                    end else if (in_opcode == mtb_pkg::OPC_CREATE &&
                                 in_amount != '0 && in_rate != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_OP;
                        if (in_bkt_ok) begin
                            vm_rd_en   = 1'b1;
                            vm_rd_word = word_t'(in_addr >> mtb_pkg::MAP_BIT_W);
                            vm_rd_bit  = mtb_pkg::map_bit_t'(in_addr);
                            bs_rd_en   = 1'b1;
                            bs_rd_addr = in_addr;
                        end
                    end
                end
            end
            S_OP: begin
                done = 1'b1;
                case (op_reg)
                    mtb_pkg::OPC_DESTROY, mtb_pkg::OPC_FETCH, mtb_pkg::OPC_RETURN: begin
                        done_slot = mtb_pkg::slot_t'(bkt_reg);
                        if (!bkt_ok || (op_reg == mtb_pkg::OPC_FETCH && amt_reg == '0)) begin
                            done_status = mtb_pkg::STAT_INVALID;
                        end else if (!vm_bit_valid) begin
                            done_status = mtb_pkg::STAT_UNUSED;
                        end else if (op_reg == mtb_pkg::OPC_DESTROY) begin
                            vm_wr      = '{en: 1'b1, set: 1'b0};
                            vm_wr_word = word_t'(bkt_addr >> mtb_pkg::MAP_BIT_W);
                            vm_wr_bit  = mtb_pkg::map_bit_t'(bkt_addr);
                        end else if (op_reg == mtb_pkg::OPC_FETCH && bs_short) begin
                            done_status = mtb_pkg::STAT_SHORT;
                            done_level  = mtb_pkg::level_out_t'(bs_level_q);
                        end else begin
                            bs_cmd.en    = 1'b1;
                            bs_cmd.op    = (op_reg == mtb_pkg::OPC_FETCH) ?
                                           mtb_pkg::LVL_SUB_AMT : mtb_pkg::LVL_ADD_AMT;
                            bs_wr_addr   = bkt_addr;
                            done_granted = amt_reg;
                            done_level   = mtb_pkg::level_out_t'(bs_new_level);
                        end
                    end
                    mtb_pkg::OPC_CREATE: begin
                        done_status = mtb_pkg::STAT_INVALID;
                    end
                    default: begin
                        done_status = mtb_pkg::STAT_INVALID;
                        done_slot   = mtb_pkg::slot_t'(bkt_reg);
                    end
                endcase
            end
            S_SCAN: begin
                if (cnt_reg != cnt_t'(NUM_WORDS)) begin
                    vm_rd_en     = 1'b1;
                    vm_rd_word   = word_t'(cnt_reg);
                    cnt_next     = cnt_reg + 1'b1;
                    wb_next      = 1'b1;
                    wb_word_next = word_t'(cnt_reg);
                end else begin
                    wb_next = 1'b0;
                end
                if (wb_reg) begin
                    if (vm_free_found) begin
                        done       = 1'b1;
                        vm_wr      = '{en: 1'b1, set: 1'b1};
                        vm_wr_word = wb_word_reg;
                        vm_wr_bit  = vm_free_bit;
                        bs_cmd     = '{en: 1'b1, op: mtb_pkg::LVL_LOAD};
                        bs_wr_addr = scan_addr;
                        done_slot  = mtb_pkg::slot_t'(scan_addr);
                        done_level = mtb_pkg::level_out_t'(bs_new_level);
                    end else if (wb_word_reg == LAST_WORD) begin
                        done        = 1'b1;
                        done_status = mtb_pkg::STAT_FULL;
                    end
                end
            end
            S_TICK: begin
                if (cnt_reg != cnt_t'(NUM_BUCKETS)) begin
                    vm_rd_en     = 1'b1;
                    vm_rd_word   = word_t'(addr_t'(cnt_reg) >> mtb_pkg::MAP_BIT_W);
                    vm_rd_bit    = mtb_pkg::map_bit_t'(addr_t'(cnt_reg));
                    bs_rd_en     = 1'b1;
                    bs_rd_addr   = addr_t'(cnt_reg);
                    cnt_next     = cnt_reg + 1'b1;
                    wb_next      = 1'b1;
                    wb_addr_next = addr_t'(cnt_reg);
                end else begin
                    wb_next = 1'b0;
                    done    = !wb_reg;
                end
                if (wb_reg && vm_bit_valid) begin
                    bs_cmd     = '{en: 1'b1, op: mtb_pkg::LVL_ADD_RATE};
                    bs_wr_addr = wb_addr_reg;
                end
            end
            S_HOLD: begin
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_granted_next   = m_granted_reg;
        m_level_next     = m_level_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_granted_next = res_granted_reg;
        res_level_next   = res_level_reg;

        if (done) begin
            if (out_free) begin
                m_tvalid_next  = 1'b1;
                m_status_next  = done_status;
                m_slot_next    = done_slot;
                m_granted_next = done_granted;
                m_level_next   = done_level;
                state_next     = S_IDLE;
            end else begin
                res_status_next  = done_status;
                res_slot_next    = done_slot;
                res_granted_next = done_granted;
                res_level_next   = done_level;
                state_next       = S_HOLD;
            end
        end else if (state_reg == S_HOLD && out_free) begin
            m_tvalid_next  = 1'b1;
            m_status_next  = res_status_reg;
            m_slot_next    = res_slot_reg;
            m_granted_next = res_granted_reg;
            m_level_next   = res_level_reg;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            wb_reg       <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            wb_reg       <= wb_next;
            cnt_reg      <= cnt_next;
        end
        op_reg          <= op_next;
        bkt_reg         <= bkt_next;
        amt_reg         <= amt_next;
        rate_reg        <= rate_next;
        wb_addr_reg     <= wb_addr_next;
        wb_word_reg     <= wb_word_next;
        m_status_reg    <= m_status_next;
        m_slot_reg      <= m_slot_next;
        m_granted_reg   <= m_granted_next;
        m_level_reg     <= m_level_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_granted_reg <= res_granted_next;
        res_level_reg   <= res_level_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'd0, m_level_reg, m_granted_reg, m_slot_reg};

endmodule

// ===== rtl/mtb_valid_map.sv =====
// Bitmap of live buckets, 32 buckets to a memory word, with its clearing pass
// after reset and the lowest-free-bit search over one word. Uses mtb_pkg.
module mtb_valid_map #(
    parameter int NUM_BUCKETS = mtb_pkg::DEF_NUM_BUCKETS,
    localparam int NUM_WORDS =
        (NUM_BUCKETS + mtb_pkg::MAP_WORD_W - 1) / mtb_pkg::MAP_WORD_W,
    localparam int WORD_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    output logic                   busy,
    input  logic                   rd_en,
    input  logic [WORD_BITS-1:0]   rd_word,
    input  mtb_pkg::map_bit_t      rd_bit,
    input  mtb_pkg::map_wr_t       wr,
    input  logic [WORD_BITS-1:0]   wr_word,
    input  mtb_pkg::map_bit_t      wr_bit,
    output logic                   bit_valid,
    output logic                   free_found,
    output mtb_pkg::map_bit_t      free_bit
);

    localparam int LAST_BITS = NUM_BUCKETS - (NUM_WORDS - 1) * mtb_pkg::MAP_WORD_W;
    localparam logic [mtb_pkg::MAP_WORD_W-1:0] LAST_MASK =
        (LAST_BITS == mtb_pkg::MAP_WORD_W) ? '1 :
        mtb_pkg::MAP_WORD_W'((64'd1 << LAST_BITS) - 64'd1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [mtb_pkg::MAP_WORD_W-1:0] map_word_t;

    localparam word_t LAST_WORD = word_t'(NUM_WORDS - 1);

    map_word_t             map_mem [NUM_WORDS];
    map_word_t             rd_data_reg;
    word_t                 rd_word_reg;
    mtb_pkg::map_bit_t     rd_bit_reg;
    logic                  clr_busy_reg;
    word_t                 clr_cnt_reg;
    map_word_t             wr_data;
    map_word_t             free_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == LAST_WORD) begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            map_mem[clr_cnt_reg] <= '0;
        end else if (wr.en) begin
            map_mem[wr_word] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_word];
            rd_word_reg <= rd_word;
            rd_bit_reg  <= rd_bit;
        end
    end

    always_comb begin
        wr_data         = rd_data_reg;
        wr_data[wr_bit] = wr.set;
    end

    always_comb begin
        free_mask  = ~rd_data_reg & ((rd_word_reg == LAST_WORD) ? LAST_MASK : '1);
        free_found = |free_mask;
        free_bit   = '0;
        for (int i = mtb_pkg::MAP_WORD_W - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                free_bit = mtb_pkg::map_bit_t'(i);
            end
        end
    end

    assign bit_valid = rd_data_reg[rd_bit_reg];
    assign busy      = clr_busy_reg;

endmodule

// ===== rtl/mtb_bucket_store.sv =====
// Memory of token levels and refill rates with the update (saturating on the adds)
// that is written back to it. Uses mtb_pkg.
module mtb_bucket_store #(
    parameter int NUM_BUCKETS = mtb_pkg::DEF_NUM_BUCKETS,
    parameter int LEVEL_BITS  = mtb_pkg::DEF_LEVEL_BITS,
    localparam int ADDR_BITS  = $clog2(NUM_BUCKETS)
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    input  mtb_pkg::lvl_cmd_t     cmd,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  mtb_pkg::amount_t      amount,
    input  mtb_pkg::rate_t        rate_in,
    output logic [LEVEL_BITS-1:0] level_q,
    output logic [LEVEL_BITS-1:0] new_level,
    output logic                  is_short
);

    localparam int SUM_W =
        ((LEVEL_BITS > mtb_pkg::RATE_W) ? LEVEL_BITS : mtb_pkg::RATE_W) + 1;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam level_t LEVEL_MAX = '1;

    logic [mtb_pkg::RATE_W+LEVEL_BITS-1:0] entry_mem [NUM_BUCKETS];
    level_t                                rd_level_reg;
    mtb_pkg::rate_t                        rd_rate_reg;
    mtb_pkg::rate_t                        wr_rate;

    function automatic level_t sat_add(level_t a, logic [mtb_pkg::RATE_W-1:0] b);
        sum_t s;
        s = sum_t'(a) + sum_t'(b);
        if (s > sum_t'(LEVEL_MAX)) begin
            return LEVEL_MAX;
        end
        return level_t'(s);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            entry_mem[wr_addr] <= {wr_rate, new_level};
        end
        if (rd_en) begin
            {rd_rate_reg, rd_level_reg} <= entry_mem[rd_addr];
        end
    end

    always_comb begin
        case (cmd.op)
            mtb_pkg::LVL_LOAD:     new_level = sat_add('0, amount);
            mtb_pkg::LVL_ADD_RATE: new_level = sat_add(rd_level_reg, rd_rate_reg);
            mtb_pkg::LVL_ADD_AMT:  new_level = sat_add(rd_level_reg, amount);
            mtb_pkg::LVL_SUB_AMT:  new_level = level_t'(sum_t'(rd_level_reg) - sum_t'(amount));
            default:               new_level = rd_level_reg;
        endcase
    end

    assign wr_rate  = (cmd.op == mtb_pkg::LVL_LOAD) ? rate_in : rd_rate_reg;
    assign is_short = sum_t'(rd_level_reg) < sum_t'(amount);
    assign level_q  = rd_level_reg;

endmodule
